>>> sv/pooled_bitmap_block_allocator_top_defines.svh
// Assertion macros shared by the checker of the pooled bitmap block allocator.
// Depends on nothing; included by the checker file only.
`ifndef POOLED_BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define POOLED_BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define PBBA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define PBBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/pbba_pkg.sv
// Package of the pooled bitmap block allocator: field widths, codes, defaults.
// Depends on nothing; imported by the allocator top level and its checker.
package pbba_pkg;

  localparam int DEF_MAX_POOLS  = 8;
  localparam int DEF_MAX_BLOCKS = 32;

  localparam int CFG_W    = 6;
  localparam int POOL_W   = 3;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_POOL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

>>> sv/pbba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the pool bitmaps and the pool list.
module pbba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pbba_lowzero.sv
// Priority encoder that finds the lowest clear bit of a vector.
// Depends on nothing; used for free slots and free pool ids.
module pbba_lowzero #(
  parameter int W  = 32,
  parameter int IW = (W > 1) ? $clog2(W) : 1
) (
  input  logic [W-1:0]  vec,
  output logic          found,
  output logic [IW-1:0] idx
);

  always_comb begin
    found = ~&vec;
    idx   = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (!vec[j]) begin
        idx = IW'(j);
      end
    end
  end

endmodule

>>> sv/pooled_bitmap_block_allocator_top.sv
// Top level of the pooled bitmap block allocator: control sequencer and state.
// Depends on pbba_pkg, pbba_ram and pbba_lowzero.
//
// Use: requests arrive on the in_valid/in_ready channel (cmd, free_pool,
// free_slot) and one result per request leaves on out_valid/out_ready
// (status, pool_id, slot, pool_released). blocks_per_pool is written through
// the cfg_valid/cfg_ready channel, which is always ready; write it only while
// no request is in progress.
// One request is worked on at a time. The pool bitmaps and the ordered pool
// list sit in two RAMs with registered reads, and the list is streamed one
// entry per cycle. An allocate takes a slot from the first listed pool with
// a free one, else opens a new pool or fails when no pool id is left. A
// rejected free goes straight to its result, one that keeps its pool writes
// back the cleared bitmap, and one that releases its pool also compacts the
// list entry by entry.
// Reset empties the pool list and sets blocks_per_pool to 32; no clearing
// pass is needed. A result waits in the output register while the receiver
// stalls; the next request is accepted meanwhile and holds before its own
// result until the register is free.
module pooled_bitmap_block_allocator_top
  import pbba_pkg::*;
#(
  parameter int MAX_POOLS  = DEF_MAX_POOLS,
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    blocks_per_pool,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [POOL_W-1:0]   free_pool,
  input  logic [SLOT_W-1:0]   free_slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [POOL_W-1:0]   pool_id,
  output logic [SLOT_W-1:0]   slot,
  output logic                pool_released
);

  localparam int PW  = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int PCW = $clog2(MAX_POOLS + 1);
  localparam int SW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW  = $clog2(MAX_BLOCKS + 1);

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_IDLE    = 3'd0;
  localparam logic [STATE_W-1:0] S_SCAN    = 3'd1;
  localparam logic [STATE_W-1:0] S_OPEN    = 3'd2;
  localparam logic [STATE_W-1:0] S_FREE    = 3'd3;
  localparam logic [STATE_W-1:0] S_COMPACT = 3'd4;
  localparam logic [STATE_W-1:0] S_DONE    = 3'd5;

  logic [STATE_W-1:0]  state;
  logic [CFG_W-1:0]    cfg;
  logic [MAX_POOLS-1:0] in_use;
  logic [PCW-1:0]      pool_count;

  // List streaming: ord_pend marks that ord_rdata holds list entry ord_pos,
  // bm_pend that bm_rdata holds the bitmap of pool bm_pool.
  logic                ord_pend;
  logic [PCW-1:0]      ord_pos;
  logic                bm_pend;
  logic [PW-1:0]       bm_pool;
  logic [PCW-1:0]      wr_k;
  logic [PW-1:0]       f_pool;
  logic [SLOT_W-1:0]   f_slot;

  logic [STATUS_W-1:0] r_status;
  logic [POOL_W-1:0]   r_pool;
  logic [SLOT_W-1:0]   r_slot;
  logic                r_rel;

  logic                bm_we;
  logic [PW-1:0]       bm_waddr;
  logic [MAX_BLOCKS-1:0] bm_wdata;
  logic [PW-1:0]       bm_raddr;
  logic [MAX_BLOCKS-1:0] bm_rdata;
  logic                ord_we;
  logic [PW-1:0]       ord_waddr;
  logic [PW-1:0]       ord_wdata;
  logic [PW-1:0]       ord_raddr;
  logic [PW-1:0]       ord_rdata;

  logic [CW-1:0]       cnt;
  logic [MAX_BLOCKS-1:0] mask;
  logic [MAX_BLOCKS-1:0] slot_bit;
  logic [MAX_BLOCKS-1:0] take_bit;
  logic [MAX_BLOCKS-1:0] cleared;
  logic                release_pool;
  logic                slot_found;
  logic [SW-1:0]       slot_idx;
  logic                pool_found;
  logic [PW-1:0]       new_pool;
  logic [PCW-1:0]      next_pos;
  logic                accept;
  logic [PW-1:0]       fp_idx;
  logic                free_ok;
  logic                can_open;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign next_pos  = ord_pos + PCW'(1);
  assign can_open  = 32'(pool_count) < MAX_POOLS;

  // A count of zero acts as one; a count above the bitmap width saturates.
  always_comb begin
    if (cfg == '0) begin
      cnt = CW'(1);
    end else if (32'(cfg) > MAX_BLOCKS) begin
      cnt = CW'(MAX_BLOCKS);
    end else begin
      cnt = CW'(cfg);
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      mask[j]     = j < 32'(cnt);
      slot_bit[j] = j == 32'(f_slot);
      take_bit[j] = j == 32'(slot_idx);
    end
  end

  assign cleared      = bm_rdata & ~slot_bit;
  assign release_pool = (cleared & mask) == '0;

  assign fp_idx  = PW'(free_pool);
  assign free_ok = (32'(free_pool) < MAX_POOLS) ? (in_use[fp_idx] &&
                   (32'(free_slot) < 32'(cnt))) : 1'b0;

  // Bits beyond the count are treated as used so they are never handed out.
  pbba_lowzero #(.W(MAX_BLOCKS), .IW(SW)) u_slot_pick (
    .vec   (bm_rdata | ~mask),
    .found (slot_found),
    .idx   (slot_idx)
  );

  pbba_lowzero #(.W(MAX_POOLS), .IW(PW)) u_pool_pick (
    .vec   (in_use),
    .found (pool_found),
    .idx   (new_pool)
  );

  pbba_ram #(.WIDTH(MAX_BLOCKS), .DEPTH(MAX_POOLS), .AW(PW)) u_bitmap_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  pbba_ram #(.WIDTH(PW), .DEPTH(MAX_POOLS), .AW(PW)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // Memory ports. Bitmaps of pools not in use are never read, so a released
  // pool needs no more than the zero written here and a new pool overwrites
  // its whole word.
  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = '0;
    bm_wdata  = '0;
    bm_raddr  = '0;
    ord_we    = 1'b0;
    ord_waddr = '0;
    ord_wdata = '0;
    ord_raddr = '0;
    unique case (state)
      S_IDLE: begin
        bm_raddr = fp_idx;
      end
      S_SCAN: begin
        ord_raddr = next_pos[PW-1:0];
        bm_raddr  = ord_rdata;
        if (bm_pend && slot_found) begin
          bm_we    = 1'b1;
          bm_waddr = bm_pool;
          bm_wdata = bm_rdata | take_bit;
        end
      end
      S_OPEN: begin
        if (can_open && pool_found) begin
          bm_we     = 1'b1;
          bm_waddr  = new_pool;
          bm_wdata  = MAX_BLOCKS'(1);
          ord_we    = 1'b1;
          ord_waddr = PW'(pool_count);
          ord_wdata = new_pool;
        end
      end
      S_FREE: begin
        bm_we    = 1'b1;
        bm_waddr = f_pool;
        bm_wdata = release_pool ? '0 : cleared;
      end
      S_COMPACT: begin
        ord_raddr = next_pos[PW-1:0];
        if (ord_pend && ord_rdata != f_pool) begin
          ord_we    = 1'b1;
          ord_waddr = wr_k[PW-1:0];
          ord_wdata = ord_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cfg        <= CFG_RESET;
      in_use     <= '0;
      pool_count <= '0;
      ord_pend   <= 1'b0;
      bm_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg <= blocks_per_pool;
      end
      // In S_DONE the output register is reloaded below instead.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == CMD_ALLOC) begin
              ord_pend <= 1'b1;
              ord_pos  <= '0;
              bm_pend  <= 1'b0;
              state    <= (pool_count == '0) ? S_OPEN : S_SCAN;
            end else begin
              f_pool   <= fp_idx;
              f_slot   <= free_slot;
              r_pool   <= free_pool;
              r_slot   <= free_slot;
              r_rel    <= 1'b0;
              r_status <= free_ok ? ST_OK : ST_NOT_FOUND;
              state    <= free_ok ? S_FREE : S_DONE;
            end
          end
        end
        S_SCAN: begin
          ord_pos  <= next_pos;
          ord_pend <= ord_pend && (next_pos < pool_count);
          bm_pend  <= ord_pend;
          bm_pool  <= ord_rdata;
          if (bm_pend && slot_found) begin
            r_status <= ST_OK;
            r_pool   <= POOL_W'(bm_pool);
            r_slot   <= SLOT_W'(slot_idx);
            r_rel    <= 1'b0;
            state    <= S_DONE;
          end else if (bm_pend && !ord_pend) begin
            state <= S_OPEN;
          end
        end
        S_OPEN: begin
          r_rel <= 1'b0;
          r_slot <= '0;
          if (can_open && pool_found) begin
            in_use[new_pool] <= 1'b1;
            pool_count       <= pool_count + PCW'(1);
            r_status         <= ST_OK;
            r_pool           <= POOL_W'(new_pool);
          end else begin
            r_status <= ST_NO_POOL;
            r_pool   <= '0;
          end
          state <= S_DONE;
        end
        S_FREE: begin
          if (release_pool) begin
            in_use[f_pool] <= 1'b0;
            r_rel          <= 1'b1;
            ord_pend       <= 1'b1;
            ord_pos        <= '0;
            wr_k           <= '0;
            state          <= S_COMPACT;
          end else begin
            state <= S_DONE;
          end
        end
        S_COMPACT: begin
          // Entries other than the released pool are copied down in order.
          ord_pos  <= next_pos;
          ord_pend <= ord_pend && (next_pos < pool_count);
          if (ord_pend && ord_rdata != f_pool) begin
            wr_k <= wr_k + PCW'(1);
          end
          if (!ord_pend) begin
            pool_count <= wr_k;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status        <= r_status;
            pool_id       <= r_pool;
            slot          <= r_slot;
            pool_released <= r_rel;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/pbba_checker.sv
// Port-level checker of the pooled bitmap block allocator and its bind.
// Depends on pbba_pkg and pooled_bitmap_block_allocator_top_defines.svh.
`include "pooled_bitmap_block_allocator_top_defines.svh"

module pbba_checker
  import pbba_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [POOL_W-1:0]   pool_id,
  input logic [SLOT_W-1:0]   slot,
  input logic                pool_released
);

  // A stalled result keeps its contents until the transfer.
  `PBBA_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pool_id) && $stable(slot) && $stable(pool_released), "result changed while stalled")

  // Only a successful free can release a pool.
  `PBBA_ASSERT(a_release_ok, clk, rst, out_valid && pool_released |-> status == ST_OK, "pool released on a failed request")

  // A failed allocation names no block.
  `PBBA_ASSERT(a_no_pool_zero, clk, rst, out_valid && status == ST_NO_POOL |-> pool_id == '0 && slot == '0 && !pool_released, "failed allocation carries a handle")

  // Reset leaves no result pending.
  `PBBA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result pending after reset")

endmodule

bind pooled_bitmap_block_allocator_top pbba_checker u_pbba_checker (.*);
